### src/fiic_pkg.sv
// Shared types, constants and control structures of the fragment interval insert checker.
`timescale 1ns / 1ps

package fiic_pkg;

	// Size of the run table; the result's run count field is sized for it.
	localparam int MAX_RUNS = 16;
	localparam int IDX_W = (MAX_RUNS > 1) ? $clog2(MAX_RUNS) : 1;
	localparam int CNT_W = 5;

	// Command codes.
	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_CLEAR = 1'b1;

	// Status codes.
	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_DUP = 2'd1;
	localparam logic [1:0] ST_OVERLAP = 2'd2;
	localparam logic [1:0] ST_FULL = 2'd3;

	// Input transaction.
	typedef struct packed {
		logic command;
		logic [15:0] frag_offset;
		logic [15:0] frag_end;
	} in_t;

	// Result transaction.
	typedef struct packed {
		logic [1:0] status;
		logic [CNT_W-1:0] run_count;
		logic [15:0] tail_end;
	} out_t;

	// One stored run of received bytes.
	typedef struct packed {
		logic [15:0] start;
		logic [16:0] length;
	} run_t;

	// How a command completes.
	typedef enum logic [2:0] {
		FIN_NONE,
		FIN_REPORT,
		FIN_CLEAR,
		FIN_OPEN_TAIL,
		FIN_OPEN_INNER,
		FIN_EXTEND
	} fin_op_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load_in;
		logic scan_start;
		logic rd_next;
		logic rd_last;
		fin_op_t fin_op;
		logic [1:0] fin_status;
	} ctl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_clear;
		logic reversed;
		logic empty;
		logic past_tail;
		logic off_below_tail;
		logic off_at_tail;
		logic full;
		logic no_runs;
		logic scan_overlap;
		logic dup_any;
		logic scan_last;
		logic out_free;
	} ctl_sts_t;

endpackage

### src/fragment_interval_insert_checker.sv
// Top level of the fragment interval insert checker: controller plus datapath.
`timescale 1ns / 1ps

// Tracks the byte ranges received for one datagram as a table of up to MAX_RUNS
// disjoint runs and answers each insert or clear transaction with a status, the
// run count and the tail end offset. A clear, a reversed range, a fragment past
// the tail that opens a run or overlaps, and an insert into an empty table are
// completed in the decide state; extending the last run passes through an extend state,
// since the last run is read from the table memory before it is rewritten. Any other
// fragment is compared against the stored runs one per cycle through the single
// read port of the table, scanning up to runs_used runs. The
// block works on one transaction at a time; a finished result waits in an output
// register while the next transaction is accepted, and completion is held off
// while that register is still full and stalled.
module fragment_interval_insert_checker
	import fiic_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic cmd_valid,
	output logic cmd_stall,
	input in_t cmd_data,
	output logic res_valid,
	input logic res_stall,
	output out_t res_data
);

	ctl_cmd_t ctl;
	ctl_sts_t sts;
	logic busy;

	// Controller state machine.
	fiic_controller u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.busy(busy),
		.ctl(ctl),
		.sts(sts)
	);

	// Run table and result path.
	fiic_datapath u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_data(cmd_data),
		.ctl(ctl),
		.sts(sts),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res_data(res_data)
	);

	assign cmd_stall = busy;

endmodule

### src/fiic_datapath.sv
// Datapath: run table memory, tail registers, scan compare and result register.
`timescale 1ns / 1ps

module fiic_datapath
	import fiic_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input in_t cmd_data,
	input ctl_cmd_t ctl,
	output ctl_sts_t sts,
	output logic res_valid,
	input logic res_stall,
	output out_t res_data
);

	in_t cmd_q;
	run_t run_mem [MAX_RUNS];
	run_t rd_q;
	logic [CNT_W-1:0] runs_used_q;
	logic [IDX_W-1:0] last_slot_q;
	logic [15:0] high_end_q;
	logic empty_q;
	logic [IDX_W-1:0] idx_q;
	logic dup_q;
	logic res_valid_q;
	out_t res_q;

	logic [15:0] frag_len;
	logic [17:0] run_end;
	logic touch;
	logic contained;
	logic rd_en;
	logic [IDX_W-1:0] rd_addr;
	logic wr_en;
	logic [IDX_W-1:0] wr_addr;
	run_t wr_run;
	logic [CNT_W-1:0] runs_nxt;
	logic [IDX_W-1:0] last_nxt;
	logic [15:0] high_nxt;
	logic empty_nxt;
	logic [CNT_W-1:0] idx_plus;

	// Latch the accepted transaction.
	always_ff @(posedge clk) begin
		if (ctl.load_in) begin
			cmd_q <= cmd_data;
		end
	end

	assign frag_len = cmd_q.frag_end - cmd_q.frag_offset;

	// Compare the fragment against the run read out of the table.
	assign run_end = {2'b00, rd_q.start} + {1'b0, rd_q.length};
	assign touch = !(({2'b00, cmd_q.frag_end} <= {2'b00, rd_q.start}) ||
		({2'b00, cmd_q.frag_offset} >= run_end));
	assign contained = (cmd_q.frag_offset >= rd_q.start) &&
		({2'b00, cmd_q.frag_end} <= run_end);
	assign idx_plus = CNT_W'(idx_q) + CNT_W'(1);

	// Status toward the controller.
	always_comb begin
		sts.is_clear = (cmd_q.command == CMD_CLEAR);
		sts.reversed = (cmd_q.frag_end < cmd_q.frag_offset);
		sts.empty = empty_q;
		sts.past_tail = (high_end_q < cmd_q.frag_end);
		sts.off_below_tail = (cmd_q.frag_offset < high_end_q);
		sts.off_at_tail = (cmd_q.frag_offset == high_end_q);
		sts.full = (runs_used_q >= CNT_W'(MAX_RUNS));
		sts.no_runs = (runs_used_q == '0);
		sts.scan_overlap = touch && !contained;
		sts.dup_any = dup_q || (touch && contained);
		sts.scan_last = (idx_plus >= runs_used_q);
		sts.out_free = !res_valid_q || !res_stall;
	end

	// Table read port: scan from slot zero onward, or fetch the last run.
	always_comb begin
		rd_en = ctl.scan_start || ctl.rd_next || ctl.rd_last;
		priority if (ctl.scan_start) begin
			rd_addr = '0;
		end else if (ctl.rd_next) begin
			rd_addr = idx_plus[IDX_W-1:0];
		end else begin
			rd_addr = last_slot_q;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q <= run_mem[rd_addr];
		end
	end

	// Table write port: a new run goes to the next free slot, an extension rewrites the last.
	always_comb begin
		wr_en = 1'b0;
		wr_addr = runs_used_q[IDX_W-1:0];
		wr_run.start = cmd_q.frag_offset;
		wr_run.length = {1'b0, frag_len};
		unique case (ctl.fin_op)
			FIN_OPEN_TAIL, FIN_OPEN_INNER: begin
				wr_en = 1'b1;
			end
			FIN_EXTEND: begin
				wr_en = 1'b1;
				wr_addr = last_slot_q;
				wr_run.start = rd_q.start;
				wr_run.length = rd_q.length + {1'b0, frag_len};
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			run_mem[wr_addr] <= wr_run;
		end
	end

	// Next values of the table bookkeeping when a command completes.
	always_comb begin
		runs_nxt = runs_used_q;
		last_nxt = last_slot_q;
		high_nxt = high_end_q;
		empty_nxt = empty_q;
		unique case (ctl.fin_op)
			FIN_CLEAR: begin
				runs_nxt = '0;
				last_nxt = '0;
				high_nxt = '0;
				empty_nxt = 1'b1;
			end
			FIN_OPEN_TAIL: begin
				runs_nxt = runs_used_q + CNT_W'(1);
				last_nxt = runs_used_q[IDX_W-1:0];
				high_nxt = cmd_q.frag_end;
				empty_nxt = 1'b0;
			end
			FIN_OPEN_INNER: begin
				runs_nxt = runs_used_q + CNT_W'(1);
				empty_nxt = 1'b0;
			end
			FIN_EXTEND: begin
				high_nxt = cmd_q.frag_end;
			end
			default: begin
				runs_nxt = runs_used_q;
			end
		endcase
	end

	// Bookkeeping registers and scan position.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			runs_used_q <= '0;
			last_slot_q <= '0;
			high_end_q <= '0;
			empty_q <= 1'b1;
			idx_q <= '0;
			dup_q <= 1'b0;
		end else begin
			runs_used_q <= runs_nxt;
			last_slot_q <= last_nxt;
			high_end_q <= high_nxt;
			empty_q <= empty_nxt;
			if (ctl.scan_start) begin
				idx_q <= '0;
				dup_q <= 1'b0;
			end else if (ctl.rd_next) begin
				idx_q <= idx_plus[IDX_W-1:0];
				dup_q <= sts.dup_any;
			end
		end
	end

	// Result register: filled when a command completes, emptied when taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (ctl.fin_op != FIN_NONE) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.fin_op != FIN_NONE) begin
			res_q.status <= ctl.fin_status;
			res_q.run_count <= runs_nxt;
			res_q.tail_end <= high_nxt;
		end
	end

	assign res_valid = res_valid_q;
	assign res_data = res_q;

endmodule

### src/fiic_controller.sv
// Controller: sequences the decision, the run table scan and the completion of each command.
`timescale 1ns / 1ps

module fiic_controller
	import fiic_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic cmd_valid,
	output logic busy,
	output ctl_cmd_t ctl,
	input ctl_sts_t sts
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_DECIDE,
		S_SCAN,
		S_EXTEND
	} state_t;

	state_t state_q;
	state_t state_nxt;
	fin_op_t op;
	logic [1:0] stat;
	logic done;

	assign busy = (state_q != S_IDLE);

	// Decide the next step from the current state and the datapath status.
	always_comb begin
		ctl = '0;
		ctl.fin_op = FIN_NONE;
		op = FIN_NONE;
		stat = ST_OK;
		done = 1'b0;
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				ctl.load_in = cmd_valid;
				if (cmd_valid) begin
					state_nxt = S_DECIDE;
				end
			end
			S_DECIDE: begin
				priority if (sts.is_clear) begin
					done = 1'b1;
					op = FIN_CLEAR;
				end else if (sts.reversed) begin
					done = 1'b1;
					op = FIN_REPORT;
					stat = ST_OVERLAP;
				end else if (sts.empty || (sts.past_tail && !sts.off_below_tail &&
						!sts.off_at_tail)) begin
					done = 1'b1;
					op = sts.full ? FIN_REPORT : FIN_OPEN_TAIL;
					stat = sts.full ? ST_FULL : ST_OK;
				end else if (sts.past_tail && sts.off_below_tail) begin
					done = 1'b1;
					op = FIN_REPORT;
					stat = ST_OVERLAP;
				end else if (sts.past_tail) begin
					ctl.rd_last = 1'b1;
					state_nxt = S_EXTEND;
				end else if (sts.no_runs) begin
					done = 1'b1;
					op = sts.full ? FIN_REPORT : FIN_OPEN_INNER;
					stat = sts.full ? ST_FULL : ST_OK;
				end else begin
					ctl.scan_start = 1'b1;
					state_nxt = S_SCAN;
				end
			end
			S_SCAN: begin
				priority if (sts.scan_overlap) begin
					done = 1'b1;
					op = FIN_REPORT;
					stat = ST_OVERLAP;
				end else if (sts.scan_last && sts.dup_any) begin
					done = 1'b1;
					op = FIN_REPORT;
					stat = ST_DUP;
				end else if (sts.scan_last) begin
					done = 1'b1;
					op = sts.full ? FIN_REPORT : FIN_OPEN_INNER;
					stat = sts.full ? ST_FULL : ST_OK;
				end else begin
					ctl.rd_next = 1'b1;
				end
			end
			S_EXTEND: begin
				done = 1'b1;
				op = FIN_EXTEND;
				stat = ST_OK;
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase

		// Completion waits until the result register can take the transaction.
		if (done && sts.out_free) begin
			ctl.fin_op = op;
			ctl.fin_status = stat;
			state_nxt = S_IDLE;
		end
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule
